>>> sv/gsab_pkg.sv
`timescale 1ns / 1ps
package gsab_pkg;

  localparam int EXP_DEPTH = 256;
  localparam int EXP_IDX_W = 8;
  localparam int QDEPTH    = 8;
  localparam int QPTR_W    = 3;
  localparam int QCNT_W    = 4;

  // register indexes on the configuration port
  localparam logic [1:0] CFG_ALPHA_MAX   = 2'd0;
  localparam logic [1:0] CFG_T_THRESHOLD = 2'd1;
  localparam logic [1:0] CFG_MASK_PERIOD = 2'd2;

  typedef struct packed {
    logic        fin;
    logic [15:0] alpha;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } blend_op_t;

  typedef struct packed {
    logic [16:0] t_threshold;
    logic [8:0]  mask_period;
  } back_cfg_t;

  typedef enum logic [1:0] {BK_IDLE, BK_MUL, BK_ACC} back_state_t;

  typedef logic [EXP_DEPTH-1:0][15:0] exp_rom_t;

  // round(65535*exp(-k/16)), series for exp(-1/16) then repeated q62 products
  function automatic exp_rom_t build_exp_rom();
    logic [63:0]  term;
    logic [63:0]  r;
    logic [63:0]  v;
    logic [127:0] prod;
    exp_rom_t     rom;
    term = 64'h4000_0000_0000_0000;
    r    = term;
    v    = term;
    for (int n = 1; n <= 20; n++) begin
      term = term / 64'(16 * n);
      if ((n % 2) == 1) r = r - term;
      else r = r + term;
    end
    for (int k = 0; k < EXP_DEPTH; k++) begin
      rom[k] = 16'(((64'd65535 * (v >> 20)) + (64'd1 << 41)) >> 42);
      prod   = {64'd0, v} * {64'd0, r};
      v      = prod[125:62];
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

>>> sv/gsab_front.sv
`timescale 1ns / 1ps
module gsab_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_take,
  input  logic                in_func,
  input  logic signed [15:0]  in_pixel_x,
  input  logic signed [15:0]  in_pixel_y,
  input  logic signed [15:0]  in_mean_x,
  input  logic signed [15:0]  in_mean_y,
  input  logic signed [31:0]  in_conic_a,
  input  logic signed [31:0]  in_conic_2b,
  input  logic signed [31:0]  in_conic_c,
  input  logic [15:0]         in_color_red,
  input  logic [15:0]         in_color_green,
  input  logic [15:0]         in_color_blue,
  input  logic [15:0]         in_opacity,
  input  logic [15:0]         alpha_max,
  output logic                q_push,
  output gsab_pkg::blend_op_t q_wdata
);
  import gsab_pkg::*;

  typedef struct packed {
    logic        fin;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] opacity;
  } side_t;

  // valid bits of stages 1..5
  logic [4:0] v_r, v_nxt;
  side_t side1_r, side2_r, side3_r, side4_r, side5_r;

  logic signed [16:0] dx_r, dy_r;
  logic signed [31:0] a1_r, b1_r, c1_r, a2_r, b2_r, c2_r;
  logic signed [33:0] pxx_r, pxy_r, pyy_r;
  logic signed [49:0] ah_r, al_r, bh_r, bl_r, ch_r, cl_r;
  logic signed [69:0] qsum;
  logic signed [40:0] qidx;
  logic               neg_r, big_r;
  logic [EXP_IDX_W-1:0] idx_r;
  logic [15:0]        e_r;
  logic [31:0]        oe;
  logic [15:0]        alpha_raw;

  assign v_nxt = {v_r[3:0], in_take};

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else v_r <= v_nxt;
  end

  always_comb begin
    qsum = (70'(ah_r) <<< 17) + 70'(al_r) + (70'(bh_r) <<< 17) + 70'(bl_r)
         + (70'(ch_r) <<< 17) + 70'(cl_r);
    qidx = 41'(qsum >>> 29);
    oe        = {16'd0, side5_r.opacity} * {16'd0, e_r};
    alpha_raw = oe[31:16];
  end

  always_ff @(posedge clk) begin
    // stage 1: offsets from the mean
    dx_r    <= 17'(in_pixel_x) - 17'(in_mean_x);
    dy_r    <= 17'(in_pixel_y) - 17'(in_mean_y);
    a1_r    <= in_conic_a;
    b1_r    <= in_conic_2b;
    c1_r    <= in_conic_c;
    side1_r <= '{fin: in_func, red: in_color_red, green: in_color_green,
                 blue: in_color_blue, opacity: in_opacity};
    // stage 2: squares and cross term
    pxx_r   <= 34'(dx_r) * 34'(dx_r);
    pxy_r   <= 34'(dx_r) * 34'(dy_r);
    pyy_r   <= 34'(dy_r) * 34'(dy_r);
    a2_r    <= a1_r;
    b2_r    <= b1_r;
    c2_r    <= c1_r;
    side2_r <= side1_r;
    // stage 3: conic times quadratic terms, split in high and low halves
    ah_r    <= 50'(a2_r) * 50'($signed(pxx_r[33:17]));
    al_r    <= 50'(a2_r) * 50'($signed({1'b0, pxx_r[16:0]}));
    bh_r    <= 50'(b2_r) * 50'($signed(pxy_r[33:17]));
    bl_r    <= 50'(b2_r) * 50'($signed({1'b0, pxy_r[16:0]}));
    ch_r    <= 50'(c2_r) * 50'($signed(pyy_r[33:17]));
    cl_r    <= 50'(c2_r) * 50'($signed({1'b0, pyy_r[16:0]}));
    side3_r <= side2_r;
    // stage 4: sum and table index floor(8*q)
    neg_r   <= qsum[69];
    big_r   <= !qsum[69] && (qidx >= 41'(EXP_DEPTH));
    idx_r   <= qidx[EXP_IDX_W-1:0];
    side4_r <= side3_r;
    // stage 5: weight lookup
    if (neg_r) e_r <= 16'hFFFF;
    else if (big_r) e_r <= 16'd0;
    else e_r <= EXP_ROM[idx_r];
    side5_r <= side4_r;
  end

  // alpha with cap on the stage 5 outputs, into the queue
  assign q_push        = v_r[4];
  assign q_wdata.fin   = side5_r.fin;
  assign q_wdata.alpha = (alpha_raw > alpha_max) ? alpha_max : alpha_raw;
  assign q_wdata.red   = side5_r.red;
  assign q_wdata.green = side5_r.green;
  assign q_wdata.blue  = side5_r.blue;

endmodule

>>> sv/gsab_queue.sv
`timescale 1ns / 1ps
module gsab_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  gsab_pkg::blend_op_t wdata,
  input  logic                pop,
  output logic                empty,
  output gsab_pkg::blend_op_t rdata
);
  import gsab_pkg::*;

  blend_op_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= wdata;
  end

  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_r];

endmodule

>>> sv/gsab_back.sv
`timescale 1ns / 1ps
module gsab_back (
  input  logic                clk,
  input  logic                rst_n,
  input  gsab_pkg::back_cfg_t cfg,
  input  logic                q_empty,
  input  gsab_pkg::blend_op_t q_rdata,
  output logic                q_pop,
  input  logic                out_pop,
  output logic                out_empty,
  output logic [15:0]         out_red,
  output logic [15:0]         out_green,
  output logic [15:0]         out_blue
);
  import gsab_pkg::*;

  back_state_t state_r, state_nxt;
  logic [15:0] acc_r_r, acc_r_nxt, acc_g_r, acc_g_nxt, acc_b_r, acc_b_nxt;
  logic [16:0] t_r, t_nxt;
  logic        mask_r, mask_nxt;
  logic [8:0]  gc_r, gc_nxt;
  logic        ov_r, ov_nxt;
  logic [15:0] or_r, or_nxt, og_r, og_nxt, ob_r, ob_nxt;
  logic [15:0] alpha_r, alpha_nxt, cr_r, cr_nxt, cg_r, cg_nxt, cb_r, cb_nxt;
  logic [15:0] contrib_r, contrib_nxt;
  logic [32:0] at_prod;
  logic [33:0] tt_prod;
  logic [31:0] pr, pg, pb;
  logic [16:0] sr, sg, sb;

  always_comb begin
    at_prod = {17'd0, alpha_r} * {16'd0, t_r};
    tt_prod = {17'd0, t_r} * (17'h10000 - {1'b0, alpha_r});
    pr = {16'd0, cr_r} * {16'd0, contrib_r};
    pg = {16'd0, cg_r} * {16'd0, contrib_r};
    pb = {16'd0, cb_r} * {16'd0, contrib_r};
    sr = {1'b0, acc_r_r} + {1'b0, pr[31:16]};
    sg = {1'b0, acc_g_r} + {1'b0, pg[31:16]};
    sb = {1'b0, acc_b_r} + {1'b0, pb[31:16]};
  end

  always_comb begin
    state_nxt   = state_r;
    acc_r_nxt   = acc_r_r;
    acc_g_nxt   = acc_g_r;
    acc_b_nxt   = acc_b_r;
    t_nxt       = t_r;
    mask_nxt    = mask_r;
    gc_nxt      = gc_r;
    ov_nxt      = ov_r && !out_pop;
    or_nxt      = or_r;
    og_nxt      = og_r;
    ob_nxt      = ob_r;
    alpha_nxt   = alpha_r;
    cr_nxt      = cr_r;
    cg_nxt      = cg_r;
    cb_nxt      = cb_r;
    contrib_nxt = contrib_r;
    q_pop       = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          if (q_rdata.fin) begin
            if (!ov_r || out_pop) begin
              q_pop     = 1'b1;
              ov_nxt    = 1'b1;
              or_nxt    = acc_r_r;
              og_nxt    = acc_g_r;
              ob_nxt    = acc_b_r;
              acc_r_nxt = '0;
              acc_g_nxt = '0;
              acc_b_nxt = '0;
              t_nxt     = 17'h10000;
              mask_nxt  = 1'b1;
              gc_nxt    = '0;
            end
          end else begin
            q_pop     = 1'b1;
            alpha_nxt = q_rdata.alpha;
            cr_nxt    = q_rdata.red;
            cg_nxt    = q_rdata.green;
            cb_nxt    = q_rdata.blue;
            if (gc_r >= cfg.mask_period) begin
              mask_nxt = (t_r >= cfg.t_threshold);
              gc_nxt   = '0;
            end
            state_nxt = BK_MUL;
          end
        end
      end
      BK_MUL: begin
        contrib_nxt = mask_r ? at_prod[31:16] : 16'd0;
        t_nxt       = mask_r ? tt_prod[32:16] : 17'd0;
        gc_nxt      = gc_r + 1'b1;
        state_nxt   = BK_ACC;
      end
      BK_ACC: begin
        acc_r_nxt = sr[16] ? 16'hFFFF : sr[15:0];
        acc_g_nxt = sg[16] ? 16'hFFFF : sg[15:0];
        acc_b_nxt = sb[16] ? 16'hFFFF : sb[15:0];
        state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      acc_r_r <= '0;
      acc_g_r <= '0;
      acc_b_r <= '0;
      t_r     <= 17'h10000;
      mask_r  <= 1'b1;
      gc_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      acc_r_r <= acc_r_nxt;
      acc_g_r <= acc_g_nxt;
      acc_b_r <= acc_b_nxt;
      t_r     <= t_nxt;
      mask_r  <= mask_nxt;
      gc_r    <= gc_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    or_r      <= or_nxt;
    og_r      <= og_nxt;
    ob_r      <= ob_nxt;
    alpha_r   <= alpha_nxt;
    cr_r      <= cr_nxt;
    cg_r      <= cg_nxt;
    cb_r      <= cb_nxt;
    contrib_r <= contrib_nxt;
  end

  assign out_empty = !ov_r;
  assign out_red   = or_r;
  assign out_green = og_r;
  assign out_blue  = ob_r;

endmodule

>>> sv/gaussian_splat_alpha_blend.sv
`timescale 1ns / 1ps
// front-to-back alpha blending of gaussian splats into one pixel
// input side is a queue write port: a beat is taken when push is high and full low
// func 0 blends one gaussian, func 1 finishes the pixel and emits its color
// result side is a queue read port: while empty is low the oldest color is on
// out_red/out_green/out_blue and a beat leaves when pop is high
// cfg port (valid/ready, ready always high) writes alpha_max, t_threshold, mask_period
// front: five register stages (offsets, squares, conic products, sum and index,
// exp table lookup), then alpha cap on the queue write; one beat per cycle when not full
// back: serial transmittance/color recurrence; a blend beat is popped in BK_IDLE, then
// BK_MUL forms alpha*T and T*(1-alpha) and BK_ACC the color multiply-accumulate
// before the next beat is popped; a finish beat is handled in BK_IDLE alone
// a finish beat goes through the five front stages and the queue to the result register
// an 8-entry queue sits between front and back; full rises when 8 beats are pending
// a stalled result register holds its color while the back keeps blending; only
// the next finish beat waits for it to be popped
// reset clears accumulators, sets T to 1.0, mask on, registers to their defaults
module gaussian_splat_alpha_blend (
  input  logic               clk,
  input  logic               rst_n,
  // input beats
  input  logic               push,
  output logic               full,
  input  logic               in_func,
  input  logic signed [15:0] in_pixel_x,
  input  logic signed [15:0] in_pixel_y,
  input  logic signed [15:0] in_mean_x,
  input  logic signed [15:0] in_mean_y,
  input  logic signed [31:0] in_conic_a,
  input  logic signed [31:0] in_conic_2b,
  input  logic signed [31:0] in_conic_c,
  input  logic [15:0]        in_color_red,
  input  logic [15:0]        in_color_green,
  input  logic [15:0]        in_color_blue,
  input  logic [15:0]        in_opacity,
  // result beats
  output logic               empty,
  input  logic               pop,
  output logic [15:0]        out_red,
  output logic [15:0]        out_green,
  output logic [15:0]        out_blue,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [16:0]        cfg_data
);
  import gsab_pkg::*;

  logic              in_take;
  logic [QCNT_W-1:0] pend_r, pend_nxt;
  logic              q_push, q_pop, q_empty;
  blend_op_t         q_wdata, q_rdata;
  logic [15:0]       alpha_max_r, alpha_max_nxt;
  back_cfg_t         bcfg_r, bcfg_nxt;

  assign cfg_ready = 1'b1;

  // register writes, unknown index ignored
  always_comb begin
    alpha_max_nxt = alpha_max_r;
    bcfg_nxt      = bcfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_ALPHA_MAX:   alpha_max_nxt        = cfg_data[15:0];
        CFG_T_THRESHOLD: bcfg_nxt.t_threshold = cfg_data;
        CFG_MASK_PERIOD: bcfg_nxt.mask_period = cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // beats taken but not yet pulled from the queue, so the pipeline never stalls
  assign in_take  = push && !full;
  assign full     = (pend_r == QCNT_W'(QDEPTH));
  assign pend_nxt = pend_r + QCNT_W'(in_take) - QCNT_W'(q_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r             <= '0;
      alpha_max_r        <= 16'd64880;
      bcfg_r.t_threshold <= 17'd7;
      bcfg_r.mask_period <= 9'd16;
    end else begin
      pend_r      <= pend_nxt;
      alpha_max_r <= alpha_max_nxt;
      bcfg_r      <= bcfg_nxt;
    end
  end

  gsab_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_take        (in_take),
    .in_func        (in_func),
    .in_pixel_x     (in_pixel_x),
    .in_pixel_y     (in_pixel_y),
    .in_mean_x      (in_mean_x),
    .in_mean_y      (in_mean_y),
    .in_conic_a     (in_conic_a),
    .in_conic_2b    (in_conic_2b),
    .in_conic_c     (in_conic_c),
    .in_color_red   (in_color_red),
    .in_color_green (in_color_green),
    .in_color_blue  (in_color_blue),
    .in_opacity     (in_opacity),
    .alpha_max      (alpha_max_r),
    .q_push         (q_push),
    .q_wdata        (q_wdata)
  );

  gsab_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  gsab_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (bcfg_r),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_pop   (pop),
    .out_empty (empty),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue)
  );

endmodule
